// File: hdl/tlsm_pkg.sv
`default_nettype none

package tlsm_pkg;

  // Width of one stored element and of one merged result.
  localparam int unsigned DataW = 32;

  // Width of the tuser field on the slave side.
  localparam int unsigned KindW = 2;

  // Item kinds on the slave side.
  typedef enum logic [KindW-1:0] {
    KIND_FIRST  = 2'd0,  // append to the first sequence
    KIND_SECOND = 2'd1,  // append to the second sequence
    KIND_MERGE  = 2'd2,  // merge both sequences and emit
    KIND_NONE   = 2'd3   // no operation
  } kind_e;

  typedef logic [DataW-1:0] data_t;

endpackage

`default_nettype wire

// File: hdl/two_list_sorted_merge.sv
`default_nettype none

// Two-way merge of two ascending sequences held in two on-chip memories.
//
// Slave channel: tuser selects the operation (append to first, append to
// second, merge), tdata carries the signed 32-bit element for appends.
// Appends are taken back to back. An append to a full sequence
// is dropped. Kind three is dropped.
// A merge item starts a run: a prime state reads both heads, then one
// merged element per cycle goes to the master channel while it does not
// stall, tlast on the final one. The first result is registered from the
// run state, which follows the prime state. The rate is set by the single
// read port of each memory (the head that goes out is refetched from its
// memory in the same cycle). On equal heads the second sequence goes
// first. A merge with both sequences empty gives no result. Both sequences
// are empty after a run, and the block is ready for new appends.
// The slave side is held off while a run is in progress; it reopens as soon
// as the last element is in the output register, even if it is not yet
// taken. A stalled master holds the run in place, nothing is lost.
// Reset empties both sequences and drops any run; memory contents are not
// cleared, no clearing pass is needed.
module two_list_sorted_merge #(
  parameter int unsigned SEQ_DEPTH = 32
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // slave side
  input  wire                         s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire  [tlsm_pkg::DataW-1:0]  s_axis_tdata_i,   // [31:0] value
  input  wire  [tlsm_pkg::KindW-1:0]  s_axis_tuser_i,   // [1:0] kind
  // master side
  output logic                        m_axis_tvalid_o,
  input  wire                         m_axis_tready_i,
  output logic [tlsm_pkg::DataW-1:0]  m_axis_tdata_o,   // [31:0] merged_value
  output logic                        m_axis_tlast_o    // last
);

  localparam int unsigned AW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;  // address width
  localparam int unsigned CW = $clog2(SEQ_DEPTH + 1);                   // count width
  localparam int unsigned TW = CW + 1;                                  // run length width
  localparam logic [CW-1:0] DepthC = CW'(SEQ_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_RUN
  } state_e;

  state_e state_q;

  // sequence memories and their registered read data (the current heads)
  tlsm_pkg::data_t mem_a [SEQ_DEPTH];
  tlsm_pkg::data_t mem_b [SEQ_DEPTH];
  tlsm_pkg::data_t head_a_q, head_b_q;

  logic [CW-1:0] cnt_a_q, cnt_b_q;   // fill counts
  logic [CW-1:0] i_q, j_q;           // head indexes during a run
  logic [TW-1:0] n_q;                // elements emitted in this run

  logic            out_valid_q, out_last_q;
  tlsm_pkg::data_t out_data_q;

  tlsm_pkg::kind_e kind;
  logic            in_acc;
  logic            wen_a, wen_b;
  logic            ren_a, ren_b;
  logic [AW-1:0]   raddr_a, raddr_b;
  logic [CW-1:0]   i_nxt, j_nxt;
  logic [TW-1:0]   total, n_nxt;
  logic            a_av, b_av, pick_a, out_free, emit, emit_last;

  assign kind   = tlsm_pkg::kind_e'(s_axis_tuser_i);
  assign in_acc = s_axis_tvalid_i && (state_q == ST_IDLE);
  assign wen_a  = in_acc && (kind == tlsm_pkg::KIND_FIRST)  && (cnt_a_q != DepthC);
  assign wen_b  = in_acc && (kind == tlsm_pkg::KIND_SECOND) && (cnt_b_q != DepthC);

  assign total = {1'b0, cnt_a_q} + {1'b0, cnt_b_q};
  assign i_nxt = i_q + CW'(1);
  assign j_nxt = j_q + CW'(1);
  assign n_nxt = n_q + TW'(1);

  // head selection: the first head wins when strictly smaller or when the second sequence is exhausted
  assign a_av   = i_q < cnt_a_q;
  assign b_av   = j_q < cnt_b_q;
  assign pick_a = a_av && (!b_av || ($signed(head_a_q) < $signed(head_b_q)));

  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign emit      = (state_q == ST_RUN) && out_free;
  assign emit_last = emit && (n_nxt == total);

  // refetch the head that leaves; prime reads both heads at entry zero
  assign ren_a   = (state_q == ST_PRIME) || (emit && pick_a);
  assign ren_b   = (state_q == ST_PRIME) || (emit && !pick_a);
  assign raddr_a = (state_q == ST_PRIME) ? '0 : i_nxt[AW-1:0];
  assign raddr_b = (state_q == ST_PRIME) ? '0 : j_nxt[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wen_a) begin
      mem_a[cnt_a_q[AW-1:0]] <= s_axis_tdata_i;
    end
    if (ren_a) begin
      head_a_q <= mem_a[raddr_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen_b) begin
      mem_b[cnt_b_q[AW-1:0]] <= s_axis_tdata_i;
    end
    if (ren_b) begin
      head_b_q <= mem_b[raddr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i && !emit) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (wen_a) begin
            cnt_a_q <= cnt_a_q + CW'(1);
          end
          if (wen_b) begin
            cnt_b_q <= cnt_b_q + CW'(1);
          end
          if (in_acc && (kind == tlsm_pkg::KIND_MERGE) && (total != '0)) begin
            i_q     <= '0;
            j_q     <= '0;
            n_q     <= '0;
            state_q <= ST_PRIME;
          end
        end
        ST_PRIME: begin
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (emit) begin
            out_valid_q <= 1'b1;
            out_last_q  <= emit_last;
            out_data_q  <= pick_a ? head_a_q : head_b_q;
            n_q         <= n_nxt;
            if (pick_a) begin
              i_q <= i_nxt;
            end else begin
              j_q <= j_nxt;
            end
            if (emit_last) begin
              cnt_a_q <= '0;
              cnt_b_q <= '0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTH
  // a run never moves a head index past either fill count
  a_idx_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> ((i_q <= cnt_a_q) && (j_q <= cnt_b_q)))
    else $error("head index beyond fill count");

  // a run always has an element left to emit
  a_run_not_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (n_q < total))
    else $error("run outlived its length");

  // the last element empties both sequences and reopens the slave side
  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_last |=> ((cnt_a_q == '0) && (cnt_b_q == '0) && s_axis_tready_o && m_axis_tlast_o))
    else $error("sequences not emptied after last element");
`endif

endmodule

`default_nettype wire

// File: bench/merge_checker.sv
`timescale 1ns / 100ps

module merge_checker #(
  parameter int unsigned SEQ_DEPTH = 32
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         s_tvalid_i,
  input  wire                         s_tready_i,
  input  wire  [tlsm_pkg::DataW-1:0]  s_tdata_i,   // [31:0] value
  input  wire  [tlsm_pkg::KindW-1:0]  s_tuser_i,   // [1:0] kind
  input  wire                         m_tvalid_i,
  input  wire                         m_tready_i,
  input  wire  [tlsm_pkg::DataW-1:0]  m_tdata_i,   // [31:0] merged_value
  input  wire                         m_tlast_i,
  output int unsigned                 pending_o,
  output int unsigned                 errors_o
);

  localparam int unsigned AW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;

  typedef struct packed {
    tlsm_pkg::data_t value;
    logic            last;
  } merged_t;

  tlsm_pkg::data_t first_mem [SEQ_DEPTH];
  tlsm_pkg::data_t second_mem[SEQ_DEPTH];
  int unsigned     first_cnt;
  int unsigned     second_cnt;
  int unsigned     fail_cnt;
  merged_t         merged_q[$];

  // Two-way merge of both stores; ties go to the second store.
  task automatic predict_merge();
    int unsigned     i;
    int unsigned     j;
    int unsigned     n;
    int unsigned     total;
    tlsm_pkg::data_t pick;
    merged_t         res;
    i = 0;
    j = 0;
    total = first_cnt + second_cnt;
    for (n = 0; n < total; n++) begin
      if (i < first_cnt && j < second_cnt) begin
        if ($signed(first_mem[i[AW-1:0]]) < $signed(second_mem[j[AW-1:0]])) begin
          pick = first_mem[i[AW-1:0]];
          i++;
        end else begin
          pick = second_mem[j[AW-1:0]];
          j++;
        end
      end else if (i < first_cnt) begin
        pick = first_mem[i[AW-1:0]];
        i++;
      end else begin
        pick = second_mem[j[AW-1:0]];
        j++;
      end
      res.value = pick;
      res.last  = (n + 1 == total);
      merged_q.push_back(res);
    end
    first_cnt  = 0;
    second_cnt = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    merged_t want;
    if (!rst_ni) begin
      first_cnt  = 0;
      second_cnt = 0;
      fail_cnt   = 0;
      merged_q.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        case (tlsm_pkg::kind_e'(s_tuser_i))
          tlsm_pkg::KIND_FIRST: begin
            if (first_cnt < SEQ_DEPTH) begin
              first_mem[first_cnt[AW-1:0]] = s_tdata_i;
              first_cnt++;
            end
          end
          tlsm_pkg::KIND_SECOND: begin
            if (second_cnt < SEQ_DEPTH) begin
              second_mem[second_cnt[AW-1:0]] = s_tdata_i;
              second_cnt++;
            end
          end
          tlsm_pkg::KIND_MERGE: predict_merge();
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        if (merged_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, got value %0d last %b",
                   $time, $signed(m_tdata_i), m_tlast_i);
          fail_cnt++;
        end else begin
          want = merged_q.pop_front();
          if (m_tdata_i !== want.value) begin
            $display("%0t: merged_value expected %0d got %0d",
                     $time, $signed(want.value), $signed(m_tdata_i));
            fail_cnt++;
          end
          if (m_tlast_i !== want.last) begin
            $display("%0t: last expected %b got %b", $time, want.last, m_tlast_i);
            fail_cnt++;
          end
        end
      end
      pending_o <= merged_q.size();
      errors_o  <= fail_cnt;
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned SeqDepth   = 32;
  localparam int unsigned ItemGoal   = 200;     // about 220 items with the ignored ones
  localparam int unsigned CycleLimit = 200000;  // far above the slowest correct run

  logic            clk_i    = 1'b0;
  logic            rst_ni   = 1'b0;

  // slave side, driven here
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  tlsm_pkg::data_t s_tdata  = '0;
  tlsm_pkg::kind_e s_tuser  = tlsm_pkg::KIND_NONE;

  // master side, tready driven here
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  tlsm_pkg::data_t m_tdata;
  logic            m_tlast;

  logic        calm = 1'b0;  // no idling on either side while set
  int unsigned pending;
  int unsigned errors;
  int unsigned cycle_cnt = 0;
  int unsigned sent = 0;     // loads and merges accepted

  always #2 clk_i = ~clk_i;

  two_list_sorted_merge #(
    .SEQ_DEPTH(SeqDepth)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  merge_checker #(
    .SEQ_DEPTH(SeqDepth)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tlast_i  (m_tlast),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  // Receiver drops tready at random about 8 percent of the time, never while calm.
  always @(posedge clk_i) begin
    m_tready <= calm || ($urandom_range(99) >= 8);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Called in the time step where the previous item was taken (or later).
  // Random idle cycles drop tvalid first; tvalid stays high otherwise.
  task automatic send_item(input tlsm_pkg::kind_e kind, input tlsm_pkg::data_t value);
    while (!calm && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= value;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    if (kind != tlsm_pkg::KIND_NONE) sent++;
  endtask

  // Hold the sender off until every predicted item has come out.
  // pending is registered, so it is first read at the edge after the last accept.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Next ascending value, saturating at the top of the signed range.
  function automatic tlsm_pkg::data_t step_up(input tlsm_pkg::data_t cur, input logic narrow);
    longint nxt;
    if (narrow) nxt = longint'($signed(cur)) + longint'($urandom_range(3));
    else        nxt = longint'($signed(cur)) + longint'($urandom_range(32'h0800_0000));
    if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
    return tlsm_pkg::data_t'(nxt);
  endfunction

  // Fill both stores with na / nb values, interleaved at random with some
  // ignored items, then merge. Narrow mode packs values close together so
  // equal heads turn up; unsorted mode feeds raw random values.
  task automatic merge_round(input int unsigned na, input int unsigned nb, input bit sorted);
    tlsm_pkg::data_t first_q[$];
    tlsm_pkg::data_t second_q[$];
    tlsm_pkg::data_t va;
    tlsm_pkg::data_t vb;
    logic            narrow;
    int unsigned     k;
    narrow = 1'($urandom_range(1));
    va = narrow ? tlsm_pkg::data_t'($urandom_range(20)) - 32'd10
                : tlsm_pkg::data_t'($urandom);
    vb = narrow ? tlsm_pkg::data_t'($urandom_range(20)) - 32'd10
                : tlsm_pkg::data_t'($urandom);
    for (k = 0; k < na; k++) begin
      first_q.push_back(sorted ? va : tlsm_pkg::data_t'($urandom));
      va = step_up(va, narrow);
    end
    for (k = 0; k < nb; k++) begin
      second_q.push_back(sorted ? vb : tlsm_pkg::data_t'($urandom));
      vb = step_up(vb, narrow);
    end
    while (first_q.size() + second_q.size() != 0) begin
      if ($urandom_range(99) < 4) send_item(tlsm_pkg::KIND_NONE, tlsm_pkg::data_t'($urandom));
      if (second_q.size() == 0 || (first_q.size() != 0 && $urandom_range(1) == 1))
        send_item(tlsm_pkg::KIND_FIRST, first_q.pop_front());
      else
        send_item(tlsm_pkg::KIND_SECOND, second_q.pop_front());
    end
    send_item(tlsm_pkg::KIND_MERGE, tlsm_pkg::data_t'($urandom));
  endtask

  initial begin
    int unsigned round;
    int unsigned na;
    int unsigned nb;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    send_item(tlsm_pkg::KIND_MERGE, '0);               // both stores empty: no output
    send_item(tlsm_pkg::KIND_NONE, 32'hFFFF_FFFF);     // kind three is dropped
    send_item(tlsm_pkg::KIND_FIRST, 32'h8000_0000);    // range extremes, equal heads
    send_item(tlsm_pkg::KIND_FIRST, 32'h0000_0000);
    send_item(tlsm_pkg::KIND_FIRST, 32'h7FFF_FFFF);
    send_item(tlsm_pkg::KIND_SECOND, 32'h8000_0000);
    send_item(tlsm_pkg::KIND_SECOND, 32'hFFFF_FFFF);
    send_item(tlsm_pkg::KIND_SECOND, 32'h7FFF_FFFF);
    send_item(tlsm_pkg::KIND_MERGE, 32'hFFFF_FFFF);
    send_item(tlsm_pkg::KIND_FIRST, 32'd5);            // only the first store
    send_item(tlsm_pkg::KIND_MERGE, '0);
    send_item(tlsm_pkg::KIND_SECOND, -32'sd3);         // only the second store
    send_item(tlsm_pkg::KIND_MERGE, '0);
    send_item(tlsm_pkg::KIND_FIRST, 32'd7);            // unsorted input
    send_item(tlsm_pkg::KIND_FIRST, 32'd3);
    send_item(tlsm_pkg::KIND_SECOND, 32'd5);
    send_item(tlsm_pkg::KIND_SECOND, 32'd4);
    send_item(tlsm_pkg::KIND_MERGE, '0);

    // Random part: mostly sorted runs of small size, a few overfilled
    // stores (both full gives the longest run), some unsorted runs.
    round = 0;
    while (sent < ItemGoal) begin
      round++;
      calm = (round >= 4 && round < 10);
      if (round == 2 || $urandom_range(29) == 0) begin
        na = $urandom_range(SeqDepth - 2, SeqDepth + 2);
        nb = (round == 2) ? SeqDepth + 1 : $urandom_range(SeqDepth - 2, SeqDepth + 2);
      end else begin
        na = $urandom_range(8);
        nb = $urandom_range(8);
      end
      merge_round(na, nb, $urandom_range(99) >= 15);
      if (round == 7 || $urandom_range(19) == 0) wait_drained();
    end
    calm = 1'b0;

    // Drain and let any stray output show up.
    wait_drained();
    repeat (16) @(posedge clk_i);

    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// File: two_list_sorted_merge.f
hdl/tlsm_pkg.sv
hdl/two_list_sorted_merge.sv
bench/merge_checker.sv
bench/testbench.sv
